[rtl/fmiq_pkg.sv]
// fmiq_pkg: shared types and constants of the fm i/q modulator
// polynomial coefficients of the q30 sine approximation, cell payload structs
// no dependencies
package fmiq_pkg;

  localparam int unsigned Q_BITS = 31;
  localparam int unsigned HORNER_STEPS = 5;

  localparam logic [Q_BITS-1:0] Q30_ONE = 31'h4000_0000;

  localparam logic [Q_BITS-1:0] C1  = 31'd1686629713;
  localparam logic [Q_BITS-1:0] C3  = 31'd693598668;
  localparam logic [Q_BITS-1:0] C5  = 31'd85569306;
  localparam logic [Q_BITS-1:0] C7  = 31'd5026995;
  localparam logic [Q_BITS-1:0] C9  = 31'd172273;
  localparam logic [Q_BITS-1:0] C11 = 31'd3864;

  localparam logic [Q_BITS-1:0] HORNER_COEF [HORNER_STEPS] = '{C9, C7, C5, C3, C1};

  localparam int unsigned AMP_BITS = 15;
  localparam logic [AMP_BITS-1:0] AMP_RESET = 15'd16383;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } fmiq_quad_t;

  typedef struct packed {
    fmiq_quad_t        quad;
    logic [Q_BITS-1:0] xs;
    logic [Q_BITS-1:0] xc;
  } fmiq_angle_t;

  typedef struct packed {
    fmiq_quad_t        quad;
    logic [Q_BITS-1:0] xs;
    logic [Q_BITS-1:0] xc;
    logic [Q_BITS-1:0] x2s;
    logic [Q_BITS-1:0] x2c;
    logic [Q_BITS-1:0] ys;
    logic [Q_BITS-1:0] yc;
  } fmiq_poly_t;

  typedef struct packed {
    logic              neg_i;
    logic              neg_q;
    logic [Q_BITS-1:0] si;
    logic [Q_BITS-1:0] sq;
  } fmiq_sine_t;

endpackage

[rtl/fmiq_ifs.sv]
// fmiq_ifs: valid/ready channel interfaces of the fm i/q modulator
// input step channel, i/q output channel, amplitude write channel
// no dependencies
interface fmiq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] phase_step;

  modport source (output valid, output phase_step, input ready);
  modport sink (input valid, input phase_step, output ready);
endinterface

interface fmiq_out_if #(
  parameter int OUT_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] i_sample;
  logic signed [OUT_WIDTH-1:0] q_sample;

  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink (input valid, input i_sample, input q_sample, output ready);
endinterface

interface fmiq_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] amplitude;

  modport source (output valid, output amplitude, input ready);
  modport sink (input valid, input amplitude, output ready);
endinterface

[rtl/fm_iq_modulator_unit.sv]
// fm_iq_modulator_unit: top level of the fm i/q modulator
// depends on fmiq_pkg, fmiq_ifs and the fmiq cell modules
//
// usage:
// - in_ch carries one signed phase step per item, in units of one
//   2^PHASE_WIDTH-th of a turn; it is added to the phase accumulator
// - out_ch returns one i/q pair per item: amplitude times cosine and sine
//   of the new phase, truncated toward zero, saturated to OUT_WIDTH bits
// - cfg writes the 15-bit amplitude; cfg.ready is always high, write it
//   only while no item is in flight
// - the chain has nine registered cells, phase, square, five horner steps,
//   final product, amplitude scaling, and the first one loads at the edge
//   that accepts the item
// - throughput is one item per clock; every cell holds its item while the
//   next one stalls, so out_ch stalls back up cell by cell and in_ch keeps
//   accepting until the chain is full
// - reset clears the phase accumulator and all cell valid flags and sets
//   amplitude to 16383
module fm_iq_modulator_unit #(
  parameter int PHASE_WIDTH = 16,
  parameter int OUT_WIDTH   = 16
) (
  input  logic          clk,
  input  logic          rst,
  fmiq_in_if.sink       in_ch,
  fmiq_out_if.source    out_ch,
  fmiq_cfg_if.sink      cfg
);

  localparam int NCELL = fmiq_pkg::HORNER_STEPS;

  logic [14:0]           amplitude;

  logic                  ang_valid;
  logic                  ang_ready;
  fmiq_pkg::fmiq_angle_t ang_data;

  logic                  poly_valid [NCELL+1];
  logic                  poly_ready [NCELL+1];
  fmiq_pkg::fmiq_poly_t  poly_data  [NCELL+1];

  logic                  sine_valid;
  logic                  sine_ready;
  fmiq_pkg::fmiq_sine_t  sine_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= fmiq_pkg::AMP_RESET;
    end else if (cfg.valid) begin
      amplitude <= cfg.amplitude;
    end
  end

  fmiq_phase_stage #(
    .PHASE_WIDTH(PHASE_WIDTH)
  ) u_phase (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .phase_step(in_ch.phase_step),
    .out_valid (ang_valid),
    .out_ready (ang_ready),
    .out_data  (ang_data)
  );

  fmiq_square_cell u_square (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ang_valid),
    .in_ready (ang_ready),
    .in_data  (ang_data),
    .out_valid(poly_valid[0]),
    .out_ready(poly_ready[0]),
    .out_data (poly_data[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_horner
    fmiq_horner_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .coef     (fmiq_pkg::HORNER_COEF[k]),
      .in_valid (poly_valid[k]),
      .in_ready (poly_ready[k]),
      .in_data  (poly_data[k]),
      .out_valid(poly_valid[k+1]),
      .out_ready(poly_ready[k+1]),
      .out_data (poly_data[k+1])
    );
  end

  fmiq_product_cell u_product (
    .clk      (clk),
    .rst      (rst),
    .in_valid (poly_valid[NCELL]),
    .in_ready (poly_ready[NCELL]),
    .in_data  (poly_data[NCELL]),
    .out_valid(sine_valid),
    .out_ready(sine_ready),
    .out_data (sine_data)
  );

  fmiq_scale_cell #(
    .OUT_WIDTH(OUT_WIDTH)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .amplitude(amplitude),
    .in_valid (sine_valid),
    .in_ready (sine_ready),
    .in_data  (sine_data),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .i_sample (out_ch.i_sample),
    .q_sample (out_ch.q_sample)
  );

endmodule

[rtl/fmiq_phase_stage.sv]
// fmiq_phase_stage: binary-angle phase accumulator and quadrant split
// first cell of the chain, produces quadrant and both sine arguments
// depends on fmiq_pkg
module fmiq_phase_stage #(
  parameter int PHASE_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       phase_step,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fmiq_pkg::fmiq_angle_t    out_data
);

  logic [PHASE_WIDTH-1:0] acc;
  logic [PHASE_WIDTH-1:0] acc_next;
  logic [31:0]            step_ext;
  logic [31:0]            turn;
  logic                   take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    step_ext = 32'(phase_step);
    acc_next = acc + step_ext[PHASE_WIDTH-1:0];
    turn     = 32'(acc_next) << (32 - PHASE_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        acc <= acc_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.quad <= fmiq_pkg::fmiq_quad_t'(turn[31:30]);
      out_data.xs   <= {1'b0, turn[29:0]};
      out_data.xc   <= fmiq_pkg::Q30_ONE - {1'b0, turn[29:0]};
    end
  end

endmodule

[rtl/fmiq_square_cell.sv]
// fmiq_square_cell: squares both sine arguments in q30
// seeds the horner chain with the highest coefficient
// depends on fmiq_pkg
module fmiq_square_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fmiq_pkg::fmiq_angle_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fmiq_pkg::fmiq_poly_t  out_data
);

  logic [61:0] sq_s;
  logic [61:0] sq_c;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sq_s = 62'(in_data.xs) * 62'(in_data.xs);
    sq_c = 62'(in_data.xc) * 62'(in_data.xc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.quad <= in_data.quad;
      out_data.xs   <= in_data.xs;
      out_data.xc   <= in_data.xc;
      out_data.x2s  <= sq_s[60:30];
      out_data.x2c  <= sq_c[60:30];
      out_data.ys   <= fmiq_pkg::C11;
      out_data.yc   <= fmiq_pkg::C11;
    end
  end

endmodule

[rtl/fmiq_horner_cell.sv]
// fmiq_horner_cell: one horner step y = coef - x2*y for sine and cosine lanes
// identical cells chained, one coefficient each
// depends on fmiq_pkg
module fmiq_horner_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [30:0]          coef,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fmiq_pkg::fmiq_poly_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fmiq_pkg::fmiq_poly_t out_data
);

  logic [61:0]          prod_s;
  logic [61:0]          prod_c;
  fmiq_pkg::fmiq_poly_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod_s       = 62'(in_data.x2s) * 62'(in_data.ys);
    prod_c       = 62'(in_data.x2c) * 62'(in_data.yc);
    data_next    = in_data;
    data_next.ys = coef - prod_s[60:30];
    data_next.yc = coef - prod_c[60:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/fmiq_product_cell.sv]
// fmiq_product_cell: final x*y of the polynomial and quadrant mapping
// routes sine and cosine magnitudes with their signs to i and q
// depends on fmiq_pkg
module fmiq_product_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fmiq_pkg::fmiq_poly_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fmiq_pkg::fmiq_sine_t out_data
);

  logic [61:0]          prod_s;
  logic [61:0]          prod_c;
  logic [30:0]          sin_mag;
  logic [30:0]          cos_mag;
  fmiq_pkg::fmiq_sine_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod_s  = 62'(in_data.xs) * 62'(in_data.ys);
    prod_c  = 62'(in_data.xc) * 62'(in_data.yc);
    sin_mag = in_data.xs[30] ? fmiq_pkg::Q30_ONE : prod_s[60:30];
    cos_mag = in_data.xc[30] ? fmiq_pkg::Q30_ONE : prod_c[60:30];
    unique case (in_data.quad)
      fmiq_pkg::QUAD_0: begin
        data_next = '{neg_i: 1'b0, neg_q: 1'b0, si: cos_mag, sq: sin_mag};
      end
      fmiq_pkg::QUAD_1: begin
        data_next = '{neg_i: 1'b1, neg_q: 1'b0, si: sin_mag, sq: cos_mag};
      end
      fmiq_pkg::QUAD_2: begin
        data_next = '{neg_i: 1'b1, neg_q: 1'b1, si: cos_mag, sq: sin_mag};
      end
      default: begin
        data_next = '{neg_i: 1'b0, neg_q: 1'b1, si: sin_mag, sq: cos_mag};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/fmiq_scale_cell.sv]
// fmiq_scale_cell: amplitude scaling, saturation and sign, output register
// last cell of the chain, drives the i/q output channel
// depends on fmiq_pkg
module fmiq_scale_cell #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [14:0]                 amplitude,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fmiq_pkg::fmiq_sine_t        in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] i_sample,
  output logic signed [OUT_WIDTH-1:0] q_sample
);

  localparam int MW = (OUT_WIDTH > 16) ? OUT_WIDTH : 16;
  localparam logic [MW-1:0] MAX_MAG = MW'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);

  logic [45:0]          prod_i;
  logic [45:0]          prod_q;
  logic [MW-1:0]        mag_i;
  logic [MW-1:0]        mag_q;
  logic [OUT_WIDTH-1:0] sat_i;
  logic [OUT_WIDTH-1:0] sat_q;
  logic [OUT_WIDTH-1:0] i_next;
  logic [OUT_WIDTH-1:0] q_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod_i = 46'(amplitude) * 46'(in_data.si);
    prod_q = 46'(amplitude) * 46'(in_data.sq);
    mag_i  = MW'(prod_i[45:30]);
    mag_q  = MW'(prod_q[45:30]);
    sat_i  = (mag_i > MAX_MAG) ? MAX_MAG[OUT_WIDTH-1:0] : mag_i[OUT_WIDTH-1:0];
    sat_q  = (mag_q > MAX_MAG) ? MAX_MAG[OUT_WIDTH-1:0] : mag_q[OUT_WIDTH-1:0];
    i_next = in_data.neg_i ? (~sat_i + 1'b1) : sat_i;
    q_next = in_data.neg_q ? (~sat_q + 1'b1) : sat_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      i_sample <= i_next;
      q_sample <= q_next;
    end
  end

endmodule
